// ===== rtl/core/cct_pkg.sv =====
// ----------------------------------------------------------------------------
// cct_pkg: calendar clock tick package
// Clock image byte offsets, calendar limits and the month length function.
// ----------------------------------------------------------------------------
package cct_pkg;

  // Clock image byte offsets
  localparam logic [7:0] BYTE_SEC    = 8'd0;
  localparam logic [7:0] BYTE_MIN    = 8'd1;
  localparam logic [7:0] BYTE_HOUR   = 8'd2;
  localparam logic [7:0] BYTE_DAY    = 8'd3;
  localparam logic [7:0] BYTE_MONTH  = 8'd4;
  localparam logic [7:0] BYTE_YEAR_L = 8'd5;
  localparam logic [7:0] BYTE_YEAR_H = 8'd6;
  localparam logic [7:0] BYTE_RUN    = 8'd7;

  // Request command codes
  localparam logic CMD_TICK  = 1'b0;
  localparam logic CMD_WRITE = 1'b1;

  // Calendar limits
  localparam logic [7:0] SEC_LIMIT   = 8'd60;
  localparam logic [7:0] MIN_LIMIT   = 8'd60;
  localparam logic [7:0] HOUR_LIMIT  = 8'd24;
  localparam logic [7:0] MONTH_LIMIT = 8'd12;

  localparam logic [7:0] FEBRUARY    = 8'd1;
  localparam logic [7:0] DAYS_SHORT  = 8'd28;
  localparam logic [7:0] DAYS_LEAP   = 8'd29;
  localparam logic [7:0] DAYS_30     = 8'd30;
  localparam logic [7:0] DAYS_31     = 8'd31;

  // Days in a zero-based month; February gets a leap day when year[1:0] is zero
  function automatic logic [7:0] month_length(input logic [7:0] month,
                                              input logic [15:0] year);
    logic [7:0] len;
    case (month)
      8'd1: len = (year[1:0] == 2'b00) ? DAYS_LEAP : DAYS_SHORT;
      8'd0, 8'd2, 8'd4, 8'd6, 8'd7, 8'd9, 8'd11: len = DAYS_31;
      default: len = DAYS_30;
    endcase
    return len;
  endfunction

endpackage

// ===== rtl/core/calendar_clock_tick.sv =====
// ----------------------------------------------------------------------------
// calendar_clock_tick: tick driven calendar clock
// Counts timer ticks and advances a second/minute/hour/day/month/year image.
// ----------------------------------------------------------------------------
// Each request is either a timer tick or a write of one clock image byte.
// A tick increments the 32-bit tick counter; when the counter turns odd and
// the running byte is set, the clock advances one second with carry through
// minutes, hours, day, month (both zero based) and year. Every request gives
// exactly one result: the full clock image as it stands after that request.
// The block takes one request per cycle unless a held result is stalled; the
// result appears in the output register in the cycle after acceptance, and a
// new request is accepted in the same cycle the held result is taken. Writes
// at byte index 8 or above only return the current image.
module calendar_clock_tick (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_cmd,
  input  logic [7:0]  in_byte_index,
  input  logic [7:0]  in_byte_value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_second_now,
  output logic [7:0]  out_minute_now,
  output logic [7:0]  out_hour_now,
  output logic [7:0]  out_day_now,
  output logic [7:0]  out_month_now,
  output logic [15:0] out_year_now,
  output logic        out_is_running,
  output logic [31:0] out_tick_count_now
);
  import cct_pkg::*;

  logic [7:0]  sec_r, sec_nxt;
  logic [7:0]  min_r, min_nxt;
  logic [7:0]  hour_r, hour_nxt;
  logic [7:0]  day_r, day_nxt;
  logic [7:0]  mon_r, mon_nxt;
  logic [15:0] year_r, year_nxt;
  logic        run_r, run_nxt;
  logic [31:0] tick_r, tick_nxt;
  logic        out_valid_r;
  logic        accept;

  logic [7:0]  sec_inc, min_inc, hour_inc, day_inc, mon_inc;
  logic        sec_carry, min_carry, hour_carry, day_carry, mon_carry;
  logic        advance;

  // Stall only while a held result is not taken
  assign in_stall = out_valid_r & out_stall;
  assign accept   = in_valid & ~in_stall;

  // Carry chain for one second step
  always_comb begin
    sec_inc    = sec_r + 8'd1;
    min_inc    = min_r + 8'd1;
    hour_inc   = hour_r + 8'd1;
    day_inc    = day_r + 8'd1;
    mon_inc    = mon_r + 8'd1;
    sec_carry  = (sec_inc >= SEC_LIMIT);
    min_carry  = sec_carry & (min_inc >= MIN_LIMIT);
    hour_carry = min_carry & (hour_inc >= HOUR_LIMIT);
    day_carry  = hour_carry & (day_inc >= month_length(mon_r, year_r));
    mon_carry  = day_carry & (mon_inc >= MONTH_LIMIT);
  end

  // The counter turns odd exactly when it was even before the increment
  assign advance = (in_cmd == CMD_TICK) & ~tick_r[0] & run_r;

  // Next clock image
  always_comb begin
    sec_nxt  = sec_r;
    min_nxt  = min_r;
    hour_nxt = hour_r;
    day_nxt  = day_r;
    mon_nxt  = mon_r;
    year_nxt = year_r;
    run_nxt  = run_r;
    tick_nxt = tick_r;
    if (in_cmd == CMD_TICK) begin
      tick_nxt = tick_r + 32'd1;
      if (advance) begin
        sec_nxt = sec_carry ? 8'd0 : sec_inc;
        if (sec_carry) begin
          min_nxt = min_carry ? 8'd0 : min_inc;
        end
        if (min_carry) begin
          hour_nxt = hour_carry ? 8'd0 : hour_inc;
        end
        if (hour_carry) begin
          day_nxt = day_carry ? 8'd0 : day_inc;
        end
        if (day_carry) begin
          mon_nxt = mon_carry ? 8'd0 : mon_inc;
        end
        if (mon_carry) begin
          year_nxt = year_r + 16'd1;
        end
      end
    end else begin
      case (in_byte_index)
        BYTE_SEC:    sec_nxt  = in_byte_value;
        BYTE_MIN:    min_nxt  = in_byte_value;
        BYTE_HOUR:   hour_nxt = in_byte_value;
        BYTE_DAY:    day_nxt  = in_byte_value;
        BYTE_MONTH:  mon_nxt  = in_byte_value;
        BYTE_YEAR_L: year_nxt = {year_r[15:8], in_byte_value};
        BYTE_YEAR_H: year_nxt = {in_byte_value, year_r[7:0]};
        BYTE_RUN:    run_nxt  = |in_byte_value;
        default:     ;
      endcase
    end
  end

  // Clock state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sec_r  <= '0;
      min_r  <= '0;
      hour_r <= '0;
      day_r  <= '0;
      mon_r  <= '0;
      year_r <= '0;
      run_r  <= 1'b0;
      tick_r <= '0;
    end else if (accept) begin
      sec_r  <= sec_nxt;
      min_r  <= min_nxt;
      hour_r <= hour_nxt;
      day_r  <= day_nxt;
      mon_r  <= mon_nxt;
      year_r <= year_nxt;
      run_r  <= run_nxt;
      tick_r <= tick_nxt;
    end
  end

  // Result valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  // Result payload: load the image after each accepted request
  always_ff @(posedge clk) begin
    if (accept) begin
      out_second_now     <= sec_nxt;
      out_minute_now     <= min_nxt;
      out_hour_now       <= hour_nxt;
      out_day_now        <= day_nxt;
      out_month_now      <= mon_nxt;
      out_year_now       <= year_nxt;
      out_is_running     <= run_nxt;
      out_tick_count_now <= tick_nxt;
    end
  end

  assign out_valid = out_valid_r;

  // Every accepted request leaves a result pending
  a_accept_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_valid_r)
    else $error("accepted request left no result");

  // Clock image holds without an accepted request
  a_state_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !accept |=> ($stable(sec_r) && $stable(year_r) && $stable(tick_r)))
    else $error("clock state changed without a request");

  // A tick adds exactly one to the counter
  a_tick_counts: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_cmd == CMD_TICK) |=> tick_r == $past(tick_r) + 32'd1)
    else $error("tick counter did not step by one");

  // A write leaves the counter alone
  a_write_no_tick: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_cmd == CMD_WRITE) |=> $stable(tick_r))
    else $error("write request changed the tick counter");

  // Result tracks the clock state
  a_result_matches: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (out_tick_count_now == tick_r && out_second_now == sec_r))
    else $error("result does not match clock state");

endmodule
